/* hw/rtl/lat_pkg.sv */
// Package for the load average tracker: field widths, Q11 constants,
// register reset values and configuration register indexes.
// No dependencies.
package lat_pkg;

    localparam int CountW  = 11;
    localparam int AvgW    = 22;
    localparam int PeriodW = 16;
    localparam int DecayW  = 12;
    localparam int CfgIdxW = 8;
    localparam int CfgDataW = 16;
    localparam int QShift  = 11;
    localparam int NumAvg  = 3;

    localparam int MaxTasks = 1024;

    localparam logic [DecayW-1:0] QOne   = DecayW'(2048);
    localparam logic [AvgW-1:0]   AvgMax = AvgW'(4194303);

    localparam logic [PeriodW-1:0] PeriodReset      = PeriodW'(501);
    localparam logic [DecayW-1:0]  DecayShortReset  = DecayW'(1884);
    localparam logic [DecayW-1:0]  DecayMediumReset = DecayW'(2014);
    localparam logic [DecayW-1:0]  DecayLongReset   = DecayW'(2037);

    typedef logic [CfgIdxW-1:0] t_cfg_index;

    localparam t_cfg_index CfgUpdatePeriod = t_cfg_index'(0);
    localparam t_cfg_index CfgDecayShort   = t_cfg_index'(1);
    localparam t_cfg_index CfgDecayMedium  = t_cfg_index'(2);
    localparam t_cfg_index CfgDecayLong    = t_cfg_index'(3);

    typedef logic [AvgW-1:0]   t_avg;
    typedef logic [DecayW-1:0] t_decay;

endpackage

/* hw/rtl/load_average_tracker.sv */
// Load average tracker top level: input register, countdown, three Q11
// exponential folds and a result register.
// Depends on lat_pkg.
//
//  channel | valid        | ready        | payload
//  --------+--------------+--------------+---------------------------------------
//  in      | i_in_valid   | o_in_ready   | i_active_tasks
//  res     | o_res_valid  | i_res_ready  | o_updated, o_avg_short/medium/long
//  cfg     | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One beat per cycle sustained while the result is taken; a tick passes from the
// input register through the fold logic into the result register.
// The fold is three 22x12 and three 11x12 multiplies in parallel, combinational.
// Reset clears the averages, the countdown and loads the register defaults.
// A stalled result holds the input register; one tick waits there, no more.
// Configuration is always ready; decays act on the next tick, period on reload.
module load_average_tracker #(
    parameter int MaxTasks = lat_pkg::MaxTasks
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [lat_pkg::CountW-1:0]   i_active_tasks,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output logic                         o_updated,
    output logic [lat_pkg::AvgW-1:0]     o_avg_short,
    output logic [lat_pkg::AvgW-1:0]     o_avg_medium,
    output logic [lat_pkg::AvgW-1:0]     o_avg_long,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [lat_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [lat_pkg::CfgDataW-1:0] i_cfg_data
);

    localparam int XW = lat_pkg::AvgW + lat_pkg::DecayW + 1;
    localparam int QW = XW - lat_pkg::QShift;

    logic [lat_pkg::PeriodW-1:0] r_period;
    lat_pkg::t_decay             r_decay [lat_pkg::NumAvg];

    logic                        r_s1_valid;
    logic [lat_pkg::CountW-1:0]  r_s1_count;

    lat_pkg::t_avg               r_avg [lat_pkg::NumAvg];
    lat_pkg::t_avg               n_avg [lat_pkg::NumAvg];
    logic [lat_pkg::PeriodW-1:0] r_ticks;
    logic [lat_pkg::PeriodW-1:0] n_ticks;
    logic                        r_armed;
    logic                        n_fire;

    logic                        r_res_valid;
    logic                        r_updated;
    lat_pkg::t_avg               r_res_avg [lat_pkg::NumAvg];

    logic                        s1_adv;
    logic [lat_pkg::CountW-1:0]  count_sat;
    logic [lat_pkg::PeriodW-1:0] period_v;
    logic [lat_pkg::PeriodW-1:0] ticks_dec;

    lat_pkg::t_decay             d_sat  [lat_pkg::NumAvg];
    logic [XW-1:0]               prod_a [lat_pkg::NumAvg];
    logic [XW-1:0]               prod_b [lat_pkg::NumAvg];
    logic [XW-1:0]               x_sum  [lat_pkg::NumAvg];
    logic [QW-1:0]               q_val  [lat_pkg::NumAvg];
    logic [XW-1:0]               active_q;

    assign s1_adv      = r_s1_valid && (!r_res_valid || i_res_ready);
    assign o_in_ready  = !r_s1_valid || s1_adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= lat_pkg::PeriodReset;
            r_decay[0] <= lat_pkg::DecayShortReset;
            r_decay[1] <= lat_pkg::DecayMediumReset;
            r_decay[2] <= lat_pkg::DecayLongReset;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lat_pkg::CfgUpdatePeriod: r_period <= i_cfg_data;
                lat_pkg::CfgDecayShort:   r_decay[0] <= i_cfg_data[lat_pkg::DecayW-1:0];
                lat_pkg::CfgDecayMedium:  r_decay[1] <= i_cfg_data[lat_pkg::DecayW-1:0];
                lat_pkg::CfgDecayLong:    r_decay[2] <= i_cfg_data[lat_pkg::DecayW-1:0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_count <= i_active_tasks;
        end
    end

    // Countdown and fold.
    always_comb begin
        count_sat = (32'(r_s1_count) > 32'(MaxTasks))
                  ? lat_pkg::CountW'(MaxTasks) : r_s1_count;
        period_v  = (r_period == '0) ? lat_pkg::PeriodW'(1) : r_period;
        ticks_dec = (r_ticks != '0) ? r_ticks - lat_pkg::PeriodW'(1) : r_ticks;
        n_fire    = 1'b0;
        if (!r_armed) begin
            n_ticks = period_v;
        end else if (ticks_dec == '0) begin
            n_fire  = 1'b1;
            n_ticks = period_v;
        end else begin
            n_ticks = ticks_dec;
        end

        active_q = XW'({count_sat, lat_pkg::QShift'(0)});
        for (int k = 0; k < lat_pkg::NumAvg; k++) begin
            d_sat[k]  = (r_decay[k] > lat_pkg::QOne) ? lat_pkg::QOne : r_decay[k];
            prod_a[k] = XW'(r_avg[k]) * XW'(d_sat[k]);
            prod_b[k] = (XW'(count_sat) * XW'(lat_pkg::QOne - d_sat[k])) << lat_pkg::QShift;
            x_sum[k]  = prod_a[k] + prod_b[k]
                      + ((active_q >= XW'(r_avg[k]))
                         ? XW'(lat_pkg::QOne - lat_pkg::DecayW'(1)) : XW'(0));
            q_val[k]  = x_sum[k][XW-1:lat_pkg::QShift];
            n_avg[k]  = (q_val[k] > QW'(lat_pkg::AvgMax)) ? lat_pkg::AvgMax
                      : q_val[k][lat_pkg::AvgW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_ticks <= '0;
            for (int k = 0; k < lat_pkg::NumAvg; k++) begin
                r_avg[k] <= '0;
            end
        end else if (s1_adv) begin
            r_armed <= 1'b1;
            r_ticks <= n_ticks;
            if (n_fire) begin
                for (int k = 0; k < lat_pkg::NumAvg; k++) begin
                    r_avg[k] <= n_avg[k];
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (s1_adv) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_updated <= n_fire;
            for (int k = 0; k < lat_pkg::NumAvg; k++) begin
                r_res_avg[k] <= n_fire ? n_avg[k] : r_avg[k];
            end
        end
    end

    assign o_res_valid  = r_res_valid;
    assign o_updated    = r_updated;
    assign o_avg_short  = r_res_avg[0];
    assign o_avg_medium = r_res_avg[1];
    assign o_avg_long   = r_res_avg[2];

    a_armed_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed |-> (r_ticks != '0))
        else $error("countdown at zero while armed");

    a_unarmed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_armed |-> (r_avg[0] == '0 && r_avg[1] == '0 && r_avg[2] == '0))
        else $error("averages moved before arming");

    a_update_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_updated) |-> r_armed)
        else $error("update reported before arming");

    a_hold_no_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && !n_fire) |=>
            ($stable(r_avg[0]) && $stable(r_avg[1]) && $stable(r_avg[2])))
        else $error("averages changed on a tick without update");

endmodule
